>>> rtl/min_tracking_stack_assert.svh
// Assertion macros used by the stack datapath.
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define MTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger implies a condition at the next clock edge.
`define MTS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> rtl/mts_pkg.sv
// Shared types and codes of the min tracking stack.
package mts_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_RESP
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic exec;
    logic fill;
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_fill;
  } sts_t;

endpackage

>>> rtl/mts_ctrl.sv
// Sequencer of the min tracking stack: handshakes and operation steps.
module mts_ctrl
  import mts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = sts_i.need_fill ? S_FILL : S_RESP;
      end
      S_FILL: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    ctl_o         = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        ctl_o.capture = in_valid_i;
      end
      S_EXEC: begin
        ctl_o.exec = 1'b1;
      end
      S_FILL: begin
        ctl_o.fill = 1'b1;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/mts_datapath.sv
// Datapath of the min tracking stack: entry memory, top cache and count.
`include "min_tracking_stack_assert.svh"

module mts_datapath
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int DATA_WIDTH  = 32,
  parameter int CNT_W       = $clog2(STACK_DEPTH + 1),
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctl_t                  ctl_i,
  output sts_t                  sts_o,
  input  logic [1:0]            command_i,
  input  logic [DATA_WIDTH-1:0] push_value_i,
  output logic [DATA_WIDTH-1:0] top_value_o,
  output logic [DATA_WIDTH-1:0] min_value_o,
  output logic [CNT_W-1:0]      depth_now_o,
  output logic                  is_empty_o,
  output logic [1:0]            status_o
);

  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CntOne   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CntTwo   = CNT_W'(2);

  cmd_e                  cmd_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [DATA_WIDTH-1:0] top_val_q, top_min_q;
  logic [CNT_W-1:0]      count_q;
  status_e               status_q;

  logic [2*DATA_WIDTH-1:0] mem_q [STACK_DEPTH];
  logic [2*DATA_WIDTH-1:0] rd_q;
  logic [AW-1:0]           rd_addr;
  logic [CNT_W-1:0]        rd_cnt;
  logic                    empty, full;
  logic [DATA_WIDTH-1:0]   new_min;
  logic                    push_ok;

  assign empty   = (count_q == '0);
  assign full    = (count_q == DepthCnt);
  assign push_ok = ctl_i.exec && (cmd_q == CMD_PUSH) && !full;
  // Entry below the current top becomes the new top after a pop.
  assign rd_cnt  = count_q - CntTwo;
  assign rd_addr = rd_cnt[AW-1:0];

  always_comb begin
    new_min = val_q;
    if (!empty && ($signed(top_min_q) < $signed(val_q))) new_min = top_min_q;
  end

  assign sts_o.need_fill = (cmd_q == CMD_POP) && (count_q >= CntTwo);

  // Capture the incoming beat.
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q <= cmd_e'(command_i);
      val_q <= push_value_i;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (push_ok) mem_q[count_q[AW-1:0]] <= {val_q, new_min};
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      top_val_q <= val_q;
      top_min_q <= new_min;
    end else if (ctl_i.fill) begin
      top_val_q <= rd_q[2*DATA_WIDTH-1:DATA_WIDTH];
      top_min_q <= rd_q[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= ST_OK;
    end else if (ctl_i.exec) begin
      status_q <= ST_OK;
      case (cmd_q)
        CMD_PUSH: begin
          if (full) status_q <= ST_PUSH_FULL;
          else      count_q  <= count_q + CntOne;
        end
        CMD_POP: begin
          if (empty) status_q <= ST_POP_EMPTY;
          else       count_q  <= count_q - CntOne;
        end
        default: begin
          status_q <= ST_OK;
        end
      endcase
    end
  end

  assign top_value_o = empty ? '0 : top_val_q;
  assign min_value_o = empty ? '0 : top_min_q;
  assign depth_now_o = count_q;
  assign is_empty_o  = empty;
  assign status_o    = status_q;

  `MTS_ASSERT(a_count_bound, count_q <= DepthCnt, "entry count above stack depth")
  `MTS_ASSERT_NEXT(a_count_hold, !ctl_i.exec, $stable(count_q), "count moved outside execute")
  `MTS_ASSERT(a_full_status, (status_q != ST_PUSH_FULL) || full, "push refused on non-full stack")

endmodule

>>> rtl/min_tracking_stack.sv
// Top level of the min tracking stack.
// Bounded LIFO of signed values that reports the running minimum with every beat.
// Each entry holds its value and the minimum of itself and everything below,
// so the minimum is always read from the top entry. Commands: push, pop and
// peek (an unused code acts as peek); every input beat yields exactly one
// output beat carrying top value, minimum (both zero when empty), depth, an
// empty flag and a status code (pop on empty or push on full is refused and
// leaves the stack unchanged). One item is handled at a time: each input beat
// passes through capture, execute and result handoff before the next input
// beat is taken; a pop that leaves entries adds a top fetch, because the new
// top is fetched through the registered read port of the entry memory.
// The entry memory needs no clearing after reset.
module min_tracking_stack
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         command_i,
  input  logic [DATA_WIDTH-1:0]              push_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [DATA_WIDTH-1:0]              top_value_o,
  output logic [DATA_WIDTH-1:0]              min_value_o,
  output logic [$clog2(STACK_DEPTH + 1)-1:0] depth_now_o,
  output logic                               is_empty_o,
  output logic [1:0]                         status_o
);

  // Count width: enough bits to hold a full stack.
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  ctl_t ctl;
  sts_t sts;

  // Sequence capture, execute, optional top fetch and result handoff.
  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Hold entries, the cached top entry, the count and the result status.
  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH),
    .CNT_W       (CNT_W)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .command_i    (command_i),
    .push_value_i (push_value_i),
    .top_value_o  (top_value_o),
    .min_value_o  (min_value_o),
    .depth_now_o  (depth_now_o),
    .is_empty_o   (is_empty_o),
    .status_o     (status_o)
  );

endmodule

>>> test/min_tracking_stack_test.sv
// Self-checking testbench of the min tracking stack: directed, fill and random command streams.
module min_tracking_stack_test;
  import mts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = 1024;
  localparam int DATA_WIDTH  = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Code 3 is not in the command enum; the block treats it as a peek.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // What one output beat must carry.
  typedef struct {
    logic [DATA_WIDTH-1:0] top;
    logic [DATA_WIDTH-1:0] min;
    logic [CNT_W-1:0]      depth;
    logic                  empty;
    status_e               status;
  } stack_result_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            command_i    = CMD_PEEK;
  logic [DATA_WIDTH-1:0] push_value_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [DATA_WIDTH-1:0] top_value_o;
  logic [DATA_WIDTH-1:0] min_value_o;
  logic [CNT_W-1:0]      depth_now_o;
  logic                  is_empty_o;
  logic [1:0]            status_o;

  // Shadow copy of the stack: value and running minimum per entry.
  logic signed [DATA_WIDTH-1:0] model_vals [STACK_DEPTH];
  logic signed [DATA_WIDTH-1:0] model_mins [STACK_DEPTH];
  int unsigned                  model_count = 0;

  stack_result_t expected_results [$];
  stack_result_t want;
  int            fail_count     = 0;
  int            send_idle_pct  = 0;
  int            recv_idle_pct  = 0;

  min_tracking_stack dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .top_value_o  (top_value_o),
    .min_value_o  (min_value_o),
    .depth_now_o  (depth_now_o),
    .is_empty_o   (is_empty_o),
    .status_o     (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one command to the shadow stack and return the beat it must produce.
  // A push keeps the smaller of its value and the minimum beneath it; refused
  // commands leave the shadow untouched.
  function automatic stack_result_t predict_stack(logic [1:0] cmd,
                                                  logic signed [DATA_WIDTH-1:0] val);
    stack_result_t r;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (model_count == STACK_DEPTH) begin
          r.status = ST_PUSH_FULL;
        end else begin
          model_vals[model_count] = val;
          if (model_count != 0 && model_mins[model_count-1] < val)
            model_mins[model_count] = model_mins[model_count-1];
          else
            model_mins[model_count] = val;
          model_count++;
        end
      end
      CMD_POP: begin
        if (model_count == 0) r.status = ST_POP_EMPTY;
        else model_count--;
      end
      default: ;  // peek and the unused code change nothing
    endcase
    if (model_count != 0) begin
      r.top   = model_vals[model_count-1];
      r.min   = model_mins[model_count-1];
      r.empty = 1'b0;
    end else begin
      r.top   = '0;
      r.min   = '0;
      r.empty = 1'b1;
    end
    r.depth = CNT_W'(model_count);
    return r;
  endfunction

  // Send one input beat. Called at a rising edge; valid stays high across
  // back-to-back beats and drops only for a random sender gap.
  task automatic send_beat(logic [1:0] cmd, logic [DATA_WIDTH-1:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    push_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_stack(cmd, val));
  endtask

  // Receiver back-pressure: drop ready at the current idle rate.
  always @(posedge clk_i)
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  // Check every output beat against the oldest pending prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("output beat with no prediction pending");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (top_value_o !== want.top) begin
          $error("top_value: expected %0d, got %0d", $signed(want.top), $signed(top_value_o));
          fail_count++;
        end
        if (min_value_o !== want.min) begin
          $error("min_value: expected %0d, got %0d", $signed(want.min), $signed(min_value_o));
          fail_count++;
        end
        if (depth_now_o !== want.depth) begin
          $error("depth_now: expected %0d, got %0d", want.depth, depth_now_o);
          fail_count++;
        end
        if (is_empty_o !== want.empty) begin
          $error("is_empty: expected %0b, got %0b", want.empty, is_empty_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
      end
    end
  end

  // Values: full-range random, a narrow band around zero for ties, extremes.
  function automatic logic [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(3))
      0:       return $urandom_range(16) - 8;
      1:       return $urandom_range(1) ? VAL_MAX : VAL_MIN;
      default: return $urandom;
    endcase
  endfunction

  // Empty-stack refusals, extremes of the value range, every command code,
  // equal minima and the minimum reappearing as entries are popped.
  task automatic test_directed();
    send_beat(CMD_PEEK, '0);
    send_beat(CMD_POP, 32'h1234_5678);       // pop on empty
    send_beat(CMD_UNUSED, '1);               // unused code on empty
    send_beat(CMD_PUSH, VAL_MAX);            // pushed onto empty: its own minimum
    send_beat(CMD_PUSH, VAL_MIN);
    send_beat(CMD_PUSH, '0);
    send_beat(CMD_PUSH, '1);
    send_beat(CMD_PUSH, VAL_MIN);            // tie with the minimum beneath
    send_beat(CMD_PEEK, 32'hDEAD_BEEF);
    send_beat(CMD_UNUSED, 32'h0000_0001);
    repeat (5) send_beat(CMD_POP, VAL_MAX);  // drain to empty
    send_beat(CMD_POP, '0);                  // pop on empty again
    send_beat(CMD_PUSH, 32'd5);
    send_beat(CMD_PUSH, 32'd5);
    send_beat(CMD_PUSH, 32'd7);
    send_beat(CMD_PUSH, 32'd3);
    send_beat(CMD_POP, '0);
    repeat (3) send_beat(CMD_POP, '0);
  endtask

  // Fill to capacity, hit push on full, then drain past empty.
  task automatic test_fill_and_drain();
    repeat (STACK_DEPTH) send_beat(CMD_PUSH, pick_value());
    send_beat(CMD_PUSH, VAL_MIN);            // push on full
    send_beat(CMD_UNUSED, '0);
    send_beat(CMD_PUSH, '0);
    send_beat(CMD_PEEK, '1);
    repeat (STACK_DEPTH) begin
      if ($urandom_range(15) == 0) send_beat(CMD_PEEK, $urandom);
      send_beat(CMD_POP, $urandom);
    end
    send_beat(CMD_POP, '0);
  endtask

  // Random mix; the push share changes every few dozen beats so the depth
  // wanders up and down and hits empty now and then.
  task automatic test_random(int beats);
    int push_pct;
    int roll;
    push_pct = 50;
    for (int i = 0; i < beats; i++) begin
      if (i % 32 == 0) push_pct = 30 + 20 * $urandom_range(2);
      roll = $urandom_range(99);
      if (roll < push_pct)           send_beat(CMD_PUSH, pick_value());
      else if (roll < push_pct + 30) send_beat(CMD_POP, $urandom);
      else if (roll < 96)            send_beat(CMD_PEEK, $urandom);
      else                           send_beat(CMD_UNUSED, $urandom);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 13;
    recv_idle_pct = 72;
    test_directed();
    test_fill_and_drain();
    test_random(220);

    send_idle_pct = 72;
    recv_idle_pct = 13;
    test_random(220);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(220);

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("min_tracking_stack verification clean");
    else
      $display("min_tracking_stack verification failed");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("min_tracking_stack verification failed");
    $finish;
  end

endmodule
